>>> src/wrx_pkg.sv
// Package with the types, constants and functions shared by the scrambler files.
`timescale 1ns / 1ps

package wrx_pkg;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int TBL_ENTRIES = 32;
  localparam int TBL_BITS = 5 * TBL_ENTRIES;

  localparam logic [2:0] REG_FIRST_LOW   = 3'd0;
  localparam logic [2:0] REG_FIRST_MID   = 3'd1;
  localparam logic [2:0] REG_FIRST_HIGH  = 3'd2;
  localparam logic [2:0] REG_FIRST_ON    = 3'd3;
  localparam logic [2:0] REG_SECOND_LOW  = 3'd4;
  localparam logic [2:0] REG_SECOND_MID  = 3'd5;
  localparam logic [2:0] REG_SECOND_HIGH = 3'd6;
  localparam logic [2:0] REG_SECOND_ON   = 3'd7;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  localparam logic [4:0] DEFAULT_TBL [TBL_ENTRIES] = '{
    5'd22, 5'd27, 5'd13, 5'd31, 5'd25, 5'd15, 5'd17, 5'd23,
    5'd12, 5'd29, 5'd3,  5'd26, 5'd10, 5'd7,  5'd18, 5'd9,
    5'd2,  5'd11, 5'd2,  5'd30, 5'd8,  5'd5,  5'd16, 5'd20,
    5'd1,  5'd28, 5'd14, 5'd6,  5'd24, 5'd4,  5'd19, 5'd21
  };

  typedef struct packed {
    logic [TBL_BITS-1:0] first_tbl;
    logic                first_on;
    logic [TBL_BITS-1:0] second_tbl;
    logic                second_on;
  } cfg_t;

  typedef struct packed {
    logic [31:0] plain_word;
    logic [2:0]  valid_bytes;
    logic        message_start;
    logic        message_end;
    logic [31:0] message_key;
    logic        pick_second_table;
  } item_t;

  typedef struct packed {
    logic [31:0] cipher_word;
    logic [2:0]  out_bytes;
    logic        end_of_message;
  } res_t;

  typedef struct packed {
    logic [31:0] chain_key;
    logic [4:0]  entry_index;
    logic [31:0] start_key;
    logic        table_choice;
  } state_t;

  function automatic logic [4:0] tbl_entry(input cfg_t cfg, input logic sel,
                                           input logic [4:0] e);
    logic [TBL_BITS-1:0] tbl;
    logic                on;
    logic [7:0]          pos;
    tbl = sel ? cfg.second_tbl : cfg.first_tbl;
    on  = sel ? cfg.second_on : cfg.first_on;
    pos = {3'b000, e} * 8'd5;
    return on ? tbl[pos +: 5] : DEFAULT_TBL[e];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] dbl;
    dbl = {x, x} >> r;
    return dbl[31:0];
  endfunction

  function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] r);
    logic [15:0] dbl;
    dbl = {x, x} >> r;
    return dbl[7:0];
  endfunction

endpackage

>>> src/wrx_if.sv
// Request channel interfaces for the scrambler input and result streams.
`timescale 1ns / 1ps

interface wrx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_word;
  logic [2:0]  valid_bytes;
  logic        message_start;
  logic        message_end;
  logic [31:0] message_key;
  logic        pick_second_table;

  modport source(output valid, plain_word, valid_bytes, message_start, message_end,
                 message_key, pick_second_table, input ready);
  modport sink(input valid, plain_word, valid_bytes, message_start, message_end,
               message_key, pick_second_table, output ready);
endinterface

interface wrx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;
  logic [2:0]  out_bytes;
  logic        end_of_message;

  modport source(output valid, cipher_word, out_bytes, end_of_message, input ready);
  modport sink(input valid, cipher_word, out_bytes, end_of_message, output ready);
endinterface

>>> src/word_rotate_xor_scrambler.sv
// Top level of the word rotate and XOR scrambler.
// A request is held in the input register, then its result in the output register.
// Throughput: one request per cycle unless the result side stalls; the chain
// update is combinational in wrx_core. The input register takes a new request
// while a finished result waits in the output register. Synchronous active-low
// reset clears the chain state, the configuration registers and both valid flags.
`timescale 1ns / 1ps

module word_rotate_xor_scrambler (
  input  logic                           clk,
  input  logic                           rst_n,
  wrx_in_if.sink                         in_ch,
  wrx_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wrx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wrx_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wrx_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  wrx_pkg::cfg_t   cfg;
  wrx_pkg::item_t  in_item;
  wrx_pkg::item_t  item_r;
  logic            item_vld_r;
  wrx_pkg::res_t   res;
  wrx_pkg::res_t   res_r;
  logic            res_vld_r;
  wrx_pkg::state_t state_r;
  wrx_pkg::state_t state_nxt;
  logic            advance;
  logic            in_fire;

  wrx_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wrx_core u_core (
    .item      (item_r),
    .state     (state_r),
    .cfg       (cfg),
    .res       (res),
    .state_nxt (state_nxt)
  );

  assign in_item.plain_word        = in_ch.plain_word;
  assign in_item.valid_bytes       = in_ch.valid_bytes;
  assign in_item.message_start     = in_ch.message_start;
  assign in_item.message_end       = in_ch.message_end;
  assign in_item.message_key       = in_ch.message_key;
  assign in_item.pick_second_table = in_ch.pick_second_table;

  assign advance     = !res_vld_r || out_ch.ready;
  assign in_ch.ready = !item_vld_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_fire) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      state_r   <= '0;
    end else if (item_vld_r && advance) begin
      res_vld_r <= 1'b1;
      state_r   <= state_nxt;
    end else if (out_ch.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld_r && advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = res_vld_r;
  assign out_ch.cipher_word    = res_r.cipher_word;
  assign out_ch.out_bytes      = res_r.out_bytes;
  assign out_ch.end_of_message = res_r.end_of_message;

endmodule

>>> src/wrx_cfg_regs.sv
// APB configuration registers holding the two rotation tables and their enables.
`timescale 1ns / 1ps

module wrx_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wrx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wrx_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wrx_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output wrx_pkg::cfg_t                  cfg
);

  logic [59:0] first_low_r, first_mid_r, second_low_r, second_mid_r;
  logic [39:0] first_high_r, second_high_r;
  logic        first_on_r, second_on_r;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_low_r   <= '0;
      first_mid_r   <= '0;
      first_high_r  <= '0;
      first_on_r    <= 1'b0;
      second_low_r  <= '0;
      second_mid_r  <= '0;
      second_high_r <= '0;
      second_on_r   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        wrx_pkg::REG_FIRST_LOW:   first_low_r   <= pwdata[59:0];
        wrx_pkg::REG_FIRST_MID:   first_mid_r   <= pwdata[59:0];
        wrx_pkg::REG_FIRST_HIGH:  first_high_r  <= pwdata[39:0];
        wrx_pkg::REG_FIRST_ON:    first_on_r    <= pwdata[0];
        wrx_pkg::REG_SECOND_LOW:  second_low_r  <= pwdata[59:0];
        wrx_pkg::REG_SECOND_MID:  second_mid_r  <= pwdata[59:0];
        wrx_pkg::REG_SECOND_HIGH: second_high_r <= pwdata[39:0];
        wrx_pkg::REG_SECOND_ON:   second_on_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wrx_pkg::REG_FIRST_LOW:   prdata = {4'b0, first_low_r};
      wrx_pkg::REG_FIRST_MID:   prdata = {4'b0, first_mid_r};
      wrx_pkg::REG_FIRST_HIGH:  prdata = {24'b0, first_high_r};
      wrx_pkg::REG_FIRST_ON:    prdata = {63'b0, first_on_r};
      wrx_pkg::REG_SECOND_LOW:  prdata = {4'b0, second_low_r};
      wrx_pkg::REG_SECOND_MID:  prdata = {4'b0, second_mid_r};
      wrx_pkg::REG_SECOND_HIGH: prdata = {24'b0, second_high_r};
      wrx_pkg::REG_SECOND_ON:   prdata = {63'b0, second_on_r};
      default:                  prdata = '0;
    endcase
  end

  assign cfg.first_tbl  = {first_high_r, first_mid_r, first_low_r};
  assign cfg.first_on   = first_on_r;
  assign cfg.second_tbl = {second_high_r, second_mid_r, second_low_r};
  assign cfg.second_on  = second_on_r;

endmodule

>>> src/wrx_core.sv
// Combinational scrambling of one item and the resulting chain state update.
`timescale 1ns / 1ps

module wrx_core (
  input  wrx_pkg::item_t  item,
  input  wrx_pkg::state_t state,
  input  wrx_pkg::cfg_t   cfg,
  output wrx_pkg::res_t   res,
  output wrx_pkg::state_t state_nxt
);

  wrx_pkg::state_t eff;
  logic [2:0]  cnt;
  logic [4:0]  rot;
  logic [31:0] w;
  logic [2:0]  s;
  logic [3:0]  sh;
  logic [7:0]  a, b, c, d, a2, b2, c2, d2;
  logic [31:0] short_word;
  logic [2:0]  n [5];
  logic [7:0]  x [4];

  always_comb begin
    eff = state;
    if (item.message_start) begin
      eff.chain_key    = item.message_key;
      eff.start_key    = item.message_key;
      eff.entry_index  = 5'd0;
      eff.table_choice = item.pick_second_table;
    end
  end

  assign cnt = (item.valid_bytes > wrx_pkg::FULL_BYTES) ? wrx_pkg::FULL_BYTES
                                                        : item.valid_bytes;

  assign rot = wrx_pkg::tbl_entry(cfg, eff.table_choice, eff.entry_index);
  assign w   = wrx_pkg::rotr32(item.plain_word, rot) ^ eff.chain_key;
  assign s   = eff.chain_key[2:0];
  assign sh  = 4'd8 - {1'b0, s};
  assign a   = w[7:0];
  assign b   = w[15:8];
  assign c   = w[23:16];
  assign d   = w[31:24];
  assign a2  = a ^ (c >> sh);
  assign b2  = b - (d >> s);
  assign c2  = c ^ (a2 >> s);
  assign d2  = d - (b2 >> sh);

  always_comb begin
    n[0] = eff.entry_index[2:0];
    short_word = '0;
    for (int j = 0; j < 4; j++) begin
      x[j] = wrx_pkg::rotr8(item.plain_word[8*j +: 8], n[j]) ^ eff.start_key[8*j +: 8];
      n[j+1] = x[j][2:0];
      if (3'(j) < cnt) begin
        short_word[8*j +: 8] = x[j];
      end
    end
  end

  always_comb begin
    state_nxt = eff;
    res.out_bytes      = cnt;
    res.end_of_message = item.message_end;
    if (cnt == wrx_pkg::FULL_BYTES) begin
      res.cipher_word       = {d2, c2, b2, a2};
      state_nxt.chain_key   = w;
      state_nxt.entry_index = d2[4:0];
    end else begin
      res.cipher_word = short_word;
    end
  end

endmodule

>>> src/wrx_chk.sv
// Port-level assertion checker for the scrambler, bound to the top level.
`timescale 1ns / 1ps

module wrx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] cipher_word,
  input logic [2:0]  out_bytes
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("Input stalled although the result side is ready.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes <= 3'd4)
    else $error("Result byte count above four.");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bytes != 3'd4 |-> cipher_word[31:24] == 8'd0)
    else $error("Unused top byte of a short result is not zero.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cipher_word))
    else $error("Stalled result changed.");

endmodule

bind word_rotate_xor_scrambler wrx_chk u_wrx_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cipher_word (out_ch.cipher_word),
  .out_bytes   (out_ch.out_bytes)
);
